// ===== hw/rtl/swbs_pkg.sv =====
// Shared widths, register indexes, configuration struct and score lookup.
package swbs_pkg;

  localparam int SWBS_WINDOW_MAX = 64;

  localparam int CODE_W     = 3;
  localparam int WIN_W      = 7;
  localparam int SCORE_W    = 16;
  localparam int SUM_W      = 22;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_WIN_SIZE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCORE_A     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCORE_C     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCORE_G     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCORE_T     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SCORE_OTHER = 3'd5;

  localparam logic [CODE_W-1:0] BASE_A = 3'd0;
  localparam logic [CODE_W-1:0] BASE_C = 3'd1;
  localparam logic [CODE_W-1:0] BASE_G = 3'd2;
  localparam logic [CODE_W-1:0] BASE_T = 3'd3;

  localparam logic [WIN_W-1:0] WINDOW_RESET = 7'd31;

  typedef logic signed [SCORE_W-1:0] score_t;
  typedef logic signed [SUM_W-1:0]   sum_t;

  typedef struct packed {
    logic [WIN_W-1:0] win;    // effective window, clamped to 1..WINDOW_MAX
    logic [WIN_W-1:0] half;   // win / 2
    score_t           sc_a;
    score_t           sc_c;
    score_t           sc_g;
    score_t           sc_t;
    score_t           sc_other;
  } cfg_t;

  function automatic sum_t score_of(input cfg_t cfg, input logic [CODE_W-1:0] code);
    score_t s;
    case (code)
      BASE_A:  s = cfg.sc_a;
      BASE_C:  s = cfg.sc_c;
      BASE_G:  s = cfg.sc_g;
      BASE_T:  s = cfg.sc_t;
      default: s = cfg.sc_other;
    endcase
    return sum_t'(s);
  endfunction

endpackage

// ===== hw/rtl/swbs_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module swbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/swbs_cfg.sv =====
// Configuration registers: window length and the five base scores.
module swbs_cfg #(
  parameter int WINDOW_MAX = swbs_pkg::SWBS_WINDOW_MAX
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [swbs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [swbs_pkg::CFG_DATA_W-1:0] cfg_data,
  output swbs_pkg::cfg_t                  cfg
);
  import swbs_pkg::*;

  localparam logic [WIN_W-1:0] WIN_LIMIT = WIN_W'(WINDOW_MAX);

  logic [WIN_W-1:0] win_size;
  score_t           score_a;
  score_t           score_c;
  score_t           score_g;
  score_t           score_t_reg;
  score_t           score_other;
  logic [WIN_W-1:0] win_eff;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_size    <= WINDOW_RESET;
      score_a     <= '0;
      score_c     <= '0;
      score_g     <= '0;
      score_t_reg <= '0;
      score_other <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WIN_SIZE:    win_size    <= cfg_data[WIN_W-1:0];
        REG_SCORE_A:     score_a     <= cfg_data;
        REG_SCORE_C:     score_c     <= cfg_data;
        REG_SCORE_G:     score_g     <= cfg_data;
        REG_SCORE_T:     score_t_reg <= cfg_data;
        REG_SCORE_OTHER: score_other <= cfg_data;
        default: ;
      endcase
    end
  end

  // A zero window behaves as one, anything past the delay line as its full length.
  always_comb begin
    if (win_size == '0) begin
      win_eff = WIN_W'(1);
    end else if (win_size > WIN_LIMIT) begin
      win_eff = WIN_LIMIT;
    end else begin
      win_eff = win_size;
    end
  end

  assign cfg.win      = win_eff;
  assign cfg.half     = win_eff >> 1;
  assign cfg.sc_a     = score_a;
  assign cfg.sc_c     = score_c;
  assign cfg.sc_g     = score_g;
  assign cfg.sc_t     = score_t_reg;
  assign cfg.sc_other = score_other;

endmodule

// ===== hw/rtl/sliding_window_base_score.sv =====
// Sliding-window base score: a running window sum of per-base scores over a base stream.
//
// Input channel (in_valid/in_ready) takes one base item: a code and a last-of-sequence
// mark. Output channel (out_valid/out_ready) gives result items: the window sum, the
// running maximum of the sequence, an end-of-run mark and a too-short mark.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the window
// length (index 0) and the scores for codes A, C, G, T and other (indexes 1 to 5).
// The recent codes live in a RAM of WINDOW_MAX entries with a registered read.
// Each base is handled in order: the code leaving the window is read as the base is
// accepted, then the update step updates the sum, writes the new code and, if the base
// gives a result, loads the output register. After the last base of a sequence the
// first ceil(W/2) bases of the final window are subtracted, one result per base, so a
// sequence ends with ceil(W/2) extra results; a sequence shorter than W gives one error
// item instead. The input is taken again once the update (after a last base, the tail)
// is done, even while the last result still waits in the output register. When the
// receiver stalls, an update or tail step with a result waits for the output register.
// Reset sets the window to 31, the scores to zero and the sequence state to empty;
// the RAM is not cleared and needs no clearing pass.
module sliding_window_base_score #(
  parameter int WINDOW_MAX = swbs_pkg::SWBS_WINDOW_MAX
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [swbs_pkg::CODE_W-1:0]     base_code,
  input  logic                            final_base,
  output logic                            out_valid,
  input  logic                            out_ready,
  output swbs_pkg::sum_t                  window_sum,
  output swbs_pkg::sum_t                  running_max,
  output logic                            end_of_run,
  output logic                            too_short,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [swbs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [swbs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import swbs_pkg::*;

  localparam int PTR_W = $clog2(WINDOW_MAX);
  localparam int AX_W  = PTR_W + 1;
  localparam logic [AX_W-1:0]  WM_X    = AX_W'(WINDOW_MAX);
  localparam logic [PTR_W-1:0] PTR_TOP = PTR_W'(WINDOW_MAX - 1);

  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_STEP    = 2'd1;
  localparam logic [1:0] S_TAIL_RD = 2'd2;
  localparam logic [1:0] S_TAIL_EX = 2'd3;

  cfg_t cfg;

  logic [1:0]        state;
  logic [PTR_W-1:0]  wp;
  logic [WIN_W-1:0]  seen;
  sum_t              cur_sum;
  sum_t              best_sum;
  logic [CODE_W-1:0] code_q;
  logic              last_q;
  logic [WIN_W-1:0]  tail_idx;

  logic              in_fire;
  logic              out_free;
  logic              ram_re;
  logic              ram_we;
  logic [AX_W-1:0]   rd_off;
  logic [AX_W-1:0]   rd_raw;
  logic [PTR_W-1:0]  rd_addr;
  logic [CODE_W-1:0] rd_code;
  logic [PTR_W-1:0]  wp_next;

  logic [WIN_W-1:0]  seen_c;
  logic              full;
  sum_t              delta;
  sum_t              sum_next;
  sum_t              best_next;
  logic [WIN_W-1:0]  seen_next;
  logic              is_short;
  logic              emit;
  logic              step_go;

  logic [WIN_W-1:0]  tail_len;
  logic              tail_last;
  sum_t              tail_sum;
  logic              tail_go;

  logic              load_out;
  sum_t              out_sum_d;
  sum_t              out_max_d;
  logic              out_eor_d;
  logic              out_short_d;

  swbs_cfg #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  swbs_ram #(
    .WIDTH (CODE_W),
    .DEPTH (WINDOW_MAX)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp),
    .wdata (code_q),
    .re    (ram_re),
    .raddr (rd_addr),
    .rdata (rd_code)
  );

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // The slot W places behind the write pointer, plus the tail offset while draining.
  assign rd_off  = (state == S_TAIL_RD) ? AX_W'(tail_idx) : '0;
  assign rd_raw  = {1'b0, wp} + WM_X - AX_W'(cfg.win) + rd_off;
  assign rd_addr = (rd_raw >= WM_X) ? PTR_W'(rd_raw - WM_X) : PTR_W'(rd_raw);
  assign ram_re  = in_fire || (state == S_TAIL_RD);
  assign wp_next = (wp == PTR_TOP) ? '0 : wp + PTR_W'(1);

  // Update step for one base.
  assign seen_c    = (seen > cfg.win) ? cfg.win : seen;
  assign full      = (seen_c == cfg.win);
  assign delta     = full ? (score_of(cfg, code_q) - score_of(cfg, rd_code))
                          : score_of(cfg, code_q);
  assign sum_next  = cur_sum + delta;
  assign best_next = (sum_next > best_sum) ? sum_next : best_sum;
  assign seen_next = full ? seen_c : seen_c + WIN_W'(1);
  assign is_short  = last_q && (seen_next < cfg.win);
  assign emit      = full || is_short || (seen_c >= cfg.half);
  assign step_go   = (state == S_STEP) && (!emit || out_free);
  assign ram_we    = step_go;

  // Tail step: remove the oldest ceil(W/2) bases of the final window one base at a time.
  assign tail_len  = cfg.win - cfg.half;
  assign tail_last = (tail_idx + WIN_W'(1) == tail_len);
  assign tail_sum  = cur_sum - score_of(cfg, rd_code);
  assign tail_go   = (state == S_TAIL_EX) && out_free;

  always_comb begin
    load_out    = 1'b0;
    out_sum_d   = sum_next;
    out_max_d   = best_next;
    out_eor_d   = 1'b0;
    out_short_d = 1'b0;
    if (step_go && emit) begin
      load_out = 1'b1;
      if (is_short) begin
        out_sum_d   = '0;
        out_eor_d   = 1'b1;
        out_short_d = 1'b1;
      end
    end else if (tail_go) begin
      load_out  = 1'b1;
      out_sum_d = tail_sum;
      out_max_d = best_sum;
      out_eor_d = tail_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      wp       <= '0;
      seen     <= '0;
      cur_sum  <= '0;
      best_sum <= '1;
      tail_idx <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            state <= S_STEP;
          end
        end
        S_STEP: begin
          if (step_go) begin
            wp <= wp_next;
            if (is_short) begin
              seen     <= '0;
              cur_sum  <= '0;
              best_sum <= '1;
              state    <= S_IDLE;
            end else begin
              seen     <= seen_next;
              cur_sum  <= sum_next;
              best_sum <= best_next;
              tail_idx <= '0;
              state    <= last_q ? S_TAIL_RD : S_IDLE;
            end
          end
        end
        S_TAIL_RD: begin
          state <= S_TAIL_EX;
        end
        S_TAIL_EX: begin
          if (tail_go) begin
            if (tail_last) begin
              seen     <= '0;
              cur_sum  <= '0;
              best_sum <= '1;
              state    <= S_IDLE;
            end else begin
              cur_sum  <= tail_sum;
              tail_idx <= tail_idx + WIN_W'(1);
              state    <= S_TAIL_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      code_q <= base_code;
      last_q <= final_base;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      window_sum  <= out_sum_d;
      running_max <= out_max_d;
      end_of_run  <= out_eor_d;
      too_short   <= out_short_d;
    end
  end

  assert property (@(posedge clk) disable iff (rst) ({1'b0, wp} < WM_X))
    else $error("write pointer ran past the delay line");

  assert property (@(posedge clk) disable iff (rst) load_out |-> (!out_valid || out_ready))
    else $error("output register loaded while still holding an item");

  assert property (@(posedge clk) disable iff (rst)
      (state == S_TAIL_RD || state == S_TAIL_EX) |-> (tail_idx < tail_len))
    else $error("tail index past the first half of the window");

  assert property (@(posedge clk) disable iff (rst)
      (load_out && out_eor_d) |=> (seen == '0 && cur_sum == '0 && best_sum == sum_t'(-1)))
    else $error("sequence state not cleared after the end-of-run item");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the sliding-window base score block.
module tb;
  import swbs_pkg::*;

  localparam int WIN_MAX    = SWBS_WINDOW_MAX;
  localparam int CODE_OTHER = 4;
  localparam int STALL_MAX  = 1000;
  localparam int SETTLE     = 6;

  typedef struct {
    logic [CODE_W-1:0] code;
    logic              last;
  } base_item_t;

  typedef struct {
    sum_t sum;
    sum_t peak;
    logic eor;
    logic short_seq;
  } score_result_t;

  logic clk;
  logic rst = 1'b1;

  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [CODE_W-1:0]     base_code = '0;
  logic                  final_base = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  sum_t                  window_sum;
  sum_t                  running_max;
  logic                  end_of_run;
  logic                  too_short;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  sliding_window_base_score uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .base_code   (base_code),
    .final_base  (final_base),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .window_sum  (window_sum),
    .running_max (running_max),
    .end_of_run  (end_of_run),
    .too_short   (too_short),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // Mirror of the block's configuration and sequence state.
  logic [WIN_W-1:0]  win_reg;
  score_t            base_score [CODE_OTHER+1];
  logic [CODE_W-1:0] hist_code [WIN_MAX];
  int                hist_ptr;
  int                seq_len;
  sum_t              win_sum;
  sum_t              peak_sum;

  base_item_t    pend_bases [$];
  score_result_t expected_scores [$];
  int            bases_queued = 0;
  int            bases_taken = 0;
  int            err_count = 0;
  int            send_idle_pct = 0;
  int            recv_stall_pct = 0;
  int            quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic sum_t score_lookup(input logic [CODE_W-1:0] code);
    sum_t r;
    r = (code > CODE_OTHER) ? base_score[CODE_OTHER] : base_score[code];
    return r;
  endfunction

  function automatic void clear_sequence();
    seq_len = 0;
    win_sum = '0;
    peak_sum = '1;
  endfunction

  function automatic void expect_score(input sum_t s, input sum_t p, input logic eor,
                                       input logic short_seq);
    score_result_t r;
    r.sum = s;
    r.peak = p;
    r.eor = eor;
    r.short_seq = short_seq;
    expected_scores.push_back(r);
  endfunction

  // Advances the mirrored window by one accepted base and queues its results.
  function automatic void score_base(input logic [CODE_W-1:0] code, input logic last);
    int w;
    int half;
    int slot;
    w = (win_reg == 0) ? 1 : ((win_reg > WIN_MAX) ? WIN_MAX : int'(win_reg));
    half = w / 2;
    if (seq_len > w) seq_len = w;
    if (seq_len < w) begin
      win_sum = win_sum + score_lookup(code);
      if (win_sum > peak_sum) peak_sum = win_sum;
      seq_len++;
      // A final base that leaves the window unfilled gives only the error item.
      if (seq_len - 1 >= half && !(last && seq_len < w))
        expect_score(win_sum, peak_sum, 1'b0, 1'b0);
    end else begin
      slot = (hist_ptr + WIN_MAX - w) % WIN_MAX;
      win_sum = win_sum + score_lookup(code) - score_lookup(hist_code[slot]);
      if (win_sum > peak_sum) peak_sum = win_sum;
      expect_score(win_sum, peak_sum, 1'b0, 1'b0);
    end
    hist_code[hist_ptr] = code;
    hist_ptr = (hist_ptr + 1) % WIN_MAX;
    if (last) begin
      if (seq_len < w) begin
        expect_score('0, peak_sum, 1'b1, 1'b1);
      end else begin
        // The tail drops the oldest ceil(W/2) bases of the final window.
        for (int k = 0; k < w - half; k++) begin
          slot = (hist_ptr + WIN_MAX - w + k) % WIN_MAX;
          win_sum = win_sum - score_lookup(hist_code[slot]);
          expect_score(win_sum, peak_sum, k == w - half - 1, 1'b0);
        end
      end
      clear_sequence();
    end
  endfunction

  // Sender side.
  always @(posedge clk) begin : base_driver
    base_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        score_base(base_code, final_base);
        bases_taken++;
      end
      if (in_valid && !in_ready) begin
        // Hold the current item until it is taken.
      end else if (pend_bases.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = pend_bases.pop_front();
        in_valid <= 1'b1;
        base_code <= nxt.code;
        final_base <= nxt.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver side and checking.
  always @(posedge clk) begin : score_monitor
    score_result_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_scores.size() == 0) begin
          $error("unexpected result item: window_sum %0d running_max %0d", window_sum,
                 running_max);
          err_count++;
        end else begin
          want = expected_scores.pop_front();
          if (window_sum !== want.sum) begin
            $error("window_sum: expected %0d, got %0d", want.sum, window_sum);
            err_count++;
          end
          if (running_max !== want.peak) begin
            $error("running_max: expected %0d, got %0d", want.peak, running_max);
            err_count++;
          end
          if (end_of_run !== want.eor) begin
            $error("end_of_run: expected %0b, got %0b", want.eor, end_of_run);
            err_count++;
          end
          if (too_short !== want.short_seq) begin
            $error("too_short: expected %0b, got %0b", want.short_seq, too_short);
            err_count++;
          end
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
    begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_MAX) begin
      $display("tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic void queue_base(input int code, input logic last);
    base_item_t it;
    it.code = code[CODE_W-1:0];
    it.last = last;
    pend_bases.push_back(it);
    bases_queued++;
  endfunction

  function automatic score_t rand_score();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'sh7FFF;
    if (r == 1) return 16'sh8000;
    if (r < 5) return score_t'($urandom_range(0, 16)) - 16'sd8;
    return score_t'($urandom_range(0, 65535));
  endfunction

  // Called at a rising edge; waits until every queued base is taken and scored.
  task automatic drain();
    do @(posedge clk);
    while (bases_taken != bases_queued || expected_scores.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Writes all six registers back to back; called at a rising edge with the block idle.
  task automatic write_cfg(input int w, input score_t a, input score_t c, input score_t g,
                           input score_t t, input score_t o);
    logic [CFG_IDX_W-1:0]  idx_list [6];
    logic [CFG_DATA_W-1:0] val_list [6];
    idx_list = '{REG_WIN_SIZE, REG_SCORE_A, REG_SCORE_C, REG_SCORE_G, REG_SCORE_T,
                 REG_SCORE_OTHER};
    val_list = '{CFG_DATA_W'(w), a, c, g, t, o};
    for (int k = 0; k < 6; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx_list[k];
      cfg_data <= val_list[k];
      do @(posedge clk);
      while (!cfg_ready);
      case (idx_list[k])
        REG_WIN_SIZE:    win_reg = val_list[k][WIN_W-1:0];
        REG_SCORE_A:     base_score[BASE_A] = val_list[k];
        REG_SCORE_C:     base_score[BASE_C] = val_list[k];
        REG_SCORE_G:     base_score[BASE_G] = val_list[k];
        REG_SCORE_T:     base_score[BASE_T] = val_list[k];
        REG_SCORE_OTHER: base_score[CODE_OTHER] = val_list[k];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // Mostly sequences that fill the window, some that end too early.
  function automatic int queue_sequence(input int w);
    int len;
    if ($urandom_range(0, 99) < 20) len = $urandom_range(1, w);
    else len = $urandom_range(w, w + 8);
    for (int k = 0; k < len; k++)
      queue_base($urandom_range(0, CODE_OTHER), k == len - 1);
    return len;
  endfunction

  initial begin : stimulus
    int w;
    int n;
    int target;
    win_reg = WINDOW_RESET;
    foreach (base_score[k]) base_score[k] = '0;
    foreach (hist_code[k]) hist_code[k] = '0;
    hist_ptr = 0;
    clear_sequence();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: every code, extreme scores, short and exact-length sequences.
    write_cfg(4, 16'sh7FFF, 16'sh8000, 16'sd1, -16'sd1, 16'sd100);
    for (int k = 0; k < 8; k++) queue_base(k % (CODE_OTHER + 1), k == 7);
    queue_base(BASE_A, 1'b0);
    queue_base(BASE_C, 1'b1);
    for (int k = 0; k < 4; k++) queue_base(BASE_T, k == 3);
    queue_base(CODE_OTHER, 1'b1);
    drain();
    write_cfg(1, -16'sd5, 16'sd7, 16'sh7FFF, 16'sh8000, 16'sd3);
    queue_base(CODE_OTHER, 1'b0);
    queue_base(CODE_OTHER, 1'b0);
    queue_base(BASE_A, 1'b1);
    queue_base(BASE_G, 1'b1);
    drain();
    // Window shrinks while a sequence is still open.
    write_cfg(6, 16'sd10, -16'sd20, 16'sd30, -16'sd40, 16'sd50);
    for (int k = 0; k < 5; k++) queue_base(k, 1'b0);
    drain();
    write_cfg(3, 16'sd10, -16'sd20, 16'sd30, -16'sd40, 16'sd50);
    queue_base(BASE_G, 1'b0);
    queue_base(BASE_C, 1'b1);
    drain();

    for (int p = 0; p < 7; p++) begin
      case (p % 4)
        0: begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct <= 72; recv_stall_pct <= 0;  end
        2: begin send_idle_pct <= 0;  recv_stall_pct <= 72; end
        default: begin send_idle_pct <= 16; recv_stall_pct <= 16; end
      endcase
      case (p)
        0: w = 2;
        1: w = WIN_MAX;
        2: w = 1;
        3: w = 3;
        4: w = $urandom_range(4, 16);
        5: w = $urandom_range(17, 40);
        default: w = 5;
      endcase
      if (w == WIN_MAX)
        write_cfg(w, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
      else
        write_cfg(w, rand_score(), rand_score(), rand_score(), rand_score(), rand_score());
      target = 12;
      n = 0;
      while (n < target / 2) n += queue_sequence(w);
      // The sender holds off here until the block has emptied.
      drain();
      while (n < target) n += queue_sequence(w);
      drain();
    end

    if (err_count == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

endmodule
